>>> hdl/tpwbm_pkg.sv
`timescale 1ns / 1ps
package tpwbm_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TICK_W = 7;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned RUN_W  = 6;

    localparam logic [CMD_W-1:0] CMD_SEND     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND_SUM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECKSUM = 2'd2;

    localparam logic [IDX_W-1:0] REG_TURBO_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_TICK_LENGTH      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOW_ONE_LENGTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOW_ZERO_LENGTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_POS_LEVEL        = 3'd4;
    localparam logic [IDX_W-1:0] REG_NEG_LEVEL        = 3'd5;

    localparam logic [RUN_W-1:0] SLOW_LAST_RUN  = 6'd15;
    localparam logic [RUN_W-1:0] TURBO_LAST_RUN = 6'd32;

    typedef struct packed {
        logic              turbo_mode;
        logic [TICK_W-1:0] tick_length;
        logic [BYTE_W-1:0] slow_one_length;
        logic [BYTE_W-1:0] slow_zero_length;
        logic [BYTE_W-1:0] pos_level;
        logic [BYTE_W-1:0] neg_level;
    } t_cfg;

endpackage

>>> hdl/tpwbm_ifs.sv
`timescale 1ns / 1ps
interface tpwbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface tpwbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic [7:0] run_length;
    logic       last_run;

    modport source (output valid, output level, output run_length, output last_run,
                    input ready);
    modport sink (input valid, input level, input run_length, input last_run,
                  output ready);
endinterface

>>> hdl/tpwbm_front.sv
`timescale 1ns / 1ps
module tpwbm_front
    import tpwbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpwbm_in_if.sink          i_in,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output logic [BYTE_W-1:0] o_push_byte,
    output t_cfg              o_cfg
);

    t_cfg              r_cfg;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic              accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_sum       = r_sum;
        o_push_byte = i_in.data_byte;
        case (i_in.cmd)
            CMD_CHECKSUM: begin
                o_push_byte = r_sum;
                n_sum       = '0;
            end
            CMD_SEND_SUM: begin
                n_sum = r_sum + i_in.data_byte;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum                  <= '0;
            r_cfg.turbo_mode       <= 1'b0;
            r_cfg.tick_length      <= 7'd2;
            r_cfg.slow_one_length  <= 8'd12;
            r_cfg.slow_zero_length <= 8'd36;
            r_cfg.pos_level        <= 8'd255;
            r_cfg.neg_level        <= 8'd0;
        end else begin
            if (accept) begin
                r_sum <= n_sum;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TURBO_MODE:       r_cfg.turbo_mode       <= i_cfg_data[0];
                    REG_TICK_LENGTH:      r_cfg.tick_length      <= i_cfg_data[TICK_W-1:0];
                    REG_SLOW_ONE_LENGTH:  r_cfg.slow_one_length  <= i_cfg_data;
                    REG_SLOW_ZERO_LENGTH: r_cfg.slow_zero_length <= i_cfg_data;
                    REG_POS_LEVEL:        r_cfg.pos_level        <= i_cfg_data;
                    REG_NEG_LEVEL:        r_cfg.neg_level        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/tpwbm_fifo.sv
`timescale 1ns / 1ps
module tpwbm_fifo
    import tpwbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [BYTE_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data
);

    logic [BYTE_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp))
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> hdl/tpwbm_back.sv
`timescale 1ns / 1ps
module tpwbm_back
    import tpwbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_valid,
    input  logic [BYTE_W-1:0] i_q_byte,
    output logic              o_pop,
    tpwbm_out_if.source       o_out
);

    logic              r_busy;
    logic [BYTE_W-1:0] r_byte;
    logic [RUN_W-1:0]  r_idx;
    logic              r_ov;
    logic [BYTE_W-1:0] r_level;
    logic [BYTE_W-1:0] r_len;
    logic              r_last;

    logic              advance;
    logic [BYTE_W-1:0] t1;
    logic [BYTE_W-1:0] t2;
    logic [BYTE_W-1:0] one_len;
    logic [BYTE_W-1:0] zero_len;
    logic              bit_val;
    logic [BYTE_W-1:0] n_level;
    logic [BYTE_W-1:0] n_len;
    logic              n_last;

    assign o_pop   = !r_busy && i_q_valid;
    assign advance = r_busy && (!r_ov || o_out.ready);

    assign o_out.valid      = r_ov;
    assign o_out.level      = r_level;
    assign o_out.run_length = r_len;
    assign o_out.last_run   = r_last;

    always_comb begin
        t1       = {1'b0, (i_cfg.tick_length == '0) ? 7'd1 : i_cfg.tick_length};
        t2       = {t1[BYTE_W-2:0], 1'b0};
        one_len  = (i_cfg.slow_one_length == '0) ? 8'd1 : i_cfg.slow_one_length;
        zero_len = (i_cfg.slow_zero_length == '0) ? 8'd1 : i_cfg.slow_zero_length;
        n_level  = i_cfg.neg_level;
        n_len    = t2;
        n_last   = 1'b0;
        bit_val  = 1'b0;
        if (!i_cfg.turbo_mode) begin
            bit_val = r_byte[3'd7 - r_idx[3:1]];
            n_level = r_idx[0] ? i_cfg.neg_level : i_cfg.pos_level;
            n_len   = bit_val ? one_len : zero_len;
            n_last  = r_idx == SLOW_LAST_RUN;
        end else if (r_idx == TURBO_LAST_RUN) begin
            n_last = 1'b1;
        end else begin
            bit_val = r_byte[r_idx[4:2]];
            case (r_idx[1:0])
                2'd0: begin
                    n_level = i_cfg.neg_level;
                    n_len   = t2;
                end
                2'd1: begin
                    n_level = i_cfg.pos_level;
                    n_len   = bit_val ? t1 : t2;
                end
                2'd2: begin
                    n_level = i_cfg.neg_level;
                    n_len   = bit_val ? t2 : t1;
                end
                default: begin
                    n_level = i_cfg.pos_level;
                    n_len   = t1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= i_q_byte;
        end
        if (advance) begin
            r_level <= n_level;
            r_len   <= n_len;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance) begin
                r_idx <= r_idx + 6'd1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_last_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_last) |=> !r_busy)
        else $error("sequencer kept running after the last run");
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_idx == '0))
        else $error("byte started at a nonzero run");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= TURBO_LAST_RUN))
        else $error("run index beyond the turbo postfix");
`endif

endmodule

>>> hdl/tape_pulse_width_byte_modulator.sv
`timescale 1ns / 1ps
// Byte-to-tape-audio modulator: each request (cmd, data_byte) yields runs of
// (level, run_length), last_run marking the final run of the byte. Slow mode
// gives 16 runs MSB first; turbo mode gives 33 runs LSB first. The run
// sequencer emits one run per cycle while the output is not stalled, and
// loads a new byte from the queue only once the previous byte has ended. A
// two-entry queue sits between the request front end and the sequencer.
// Configuration must be written through i_cfg_we / i_cfg_idx / i_cfg_data
// only while no request is in flight; the block itself does not enforce this.
module tape_pulse_width_byte_modulator
    import tpwbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpwbm_in_if.sink          i_in,
    tpwbm_out_if.source       o_out,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    logic              q_full;
    logic              push;
    logic [BYTE_W-1:0] push_byte;
    logic              pop;
    logic              q_valid;
    logic [BYTE_W-1:0] q_byte;

    tpwbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_byte (push_byte),
        .o_cfg       (cfg)
    );

    tpwbm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_byte),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_byte)
    );

    tpwbm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_byte  (q_byte),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
